// ----- design/line_current_magnetic_field_defines.svh -----
// Assertion macros for the line current field block checker.
// Needs nothing else; included by the checker file only.
`ifndef LINE_CURRENT_MAGNETIC_FIELD_DEFINES_SVH
`define LINE_CURRENT_MAGNETIC_FIELD_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LCMF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcmf check failed");

// next-cycle implication, disabled in reset
`define LCMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcmf check failed");

`endif

// ----- design/lcmf_pkg.sv -----
// Shared types and constants for the line current field block.
// No dependencies; imported by the top level and its checker.
package lcmf_pkg;

    localparam int MAX_LINES_DEF = 16;
    localparam int IDX_W  = 4;
    localparam int PW     = 20;
    localparam int CFG_W  = 5;
    localparam int UW     = 18;
    localparam int WW     = 21;
    localparam int C24W   = 40;
    localparam int CW     = 31;
    localparam int SQW    = 62;
    localparam int SQKW   = 5;
    localparam int RW     = 31;
    localparam int LW     = 20;
    localparam int DNW    = 50;
    localparam int DDW    = 40;
    localparam int DCW    = 6;
    localparam int MW     = 42;
    localparam int EW     = 18;
    localparam int TW     = 60;
    localparam int ACCW   = 51;
    localparam int FW     = 32;
    localparam int KW     = 30;

    localparam logic [KW-1:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [19:0] SCALE_FLOOR = 20'h40000;

    localparam logic signed [ACCW-1:0] ACC_POS_LIM = ACCW'(33'sh07fffffff);
    localparam logic signed [ACCW-1:0] ACC_NEG_LIM = ACCW'(-33'sh080000000);
    localparam logic signed [FW-1:0] FIELD_MAX = 32'sh7fffffff;
    localparam logic signed [FW-1:0] FIELD_MIN = 32'sh80000000;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SKIP     = 2'd1,
        ST_SAT      = 2'd2,
        ST_ZERO_DIR = 2'd3
    } status_t;

    typedef struct packed {
        logic                 operation;
        logic [IDX_W-1:0]     entry_index;
        logic signed [PW-1:0] current_amps;
        logic signed [PW-1:0] pos_x;
        logic signed [PW-1:0] pos_y;
        logic signed [PW-1:0] pos_z;
        logic signed [PW-1:0] dir_x;
        logic signed [PW-1:0] dir_y;
        logic signed [PW-1:0] dir_z;
    } in_word_t;

    typedef struct packed {
        logic signed [FW-1:0] field_x;
        logic signed [FW-1:0] field_y;
        logic signed [FW-1:0] field_z;
        logic [1:0]           status;
    } out_word_t;

endpackage

// ----- design/line_current_magnetic_field.sv -----
// Field of a table of infinite straight line currents, one shared datapath.
// Depends on lcmf_pkg.
//
// Use: item words arrive on item_valid/item_ready, result words leave on
// result_valid/result_ready, one result word for every item word. A load
// word normalises its direction and writes one table entry; a query word
// walks entries 0 .. min(active_lines, MAX_LINES)-1 and sums I/(2*pi*r)
// along u x (p - a). active_lines is written via cfg_write_en/cfg_write_data;
// the user must do so only while idle; the block does not enforce it. One
// word is in work at a time; item_ready is high only while idle, and a
// finished result may still wait in the output register meanwhile. A load
// word with a zero direction goes straight to its result; else it takes up
// to 18 doubling steps, a 31-step root and three 50-step quotients. A query
// line through the point costs no root or quotient; each other line costs
// one 31-step root and four quotients from the one-bit-per-cycle divider,
// which sets the rate. Table state sits in one memory with a registered
// read. Reset clears the control state and active_lines; table entries stay
// undefined until loaded. A stalled receiver holds the result word, and the
// block then waits in its last state before taking the next word.
module line_current_magnetic_field #(
    parameter int MAX_LINES = lcmf_pkg::MAX_LINES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [lcmf_pkg::CFG_W-1:0] cfg_write_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  lcmf_pkg::in_word_t  item_word,
    output logic                result_valid,
    input  logic                result_ready,
    output lcmf_pkg::out_word_t result_word
);
    import lcmf_pkg::*;

    localparam int AW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LCW = $clog2(MAX_LINES + 1);
    localparam int IXW = IDX_W + AW;

    typedef enum logic [26:0] {
        S_IDLE     = 27'd1 << 0,
        S_L_CHK    = 27'd1 << 1,
        S_L_SCALE  = 27'd1 << 2,
        S_L_SQ_MUL = 27'd1 << 3,
        S_L_SQ_ACC = 27'd1 << 4,
        S_L_SQRT   = 27'd1 << 5,
        S_L_DIV_GO = 27'd1 << 6,
        S_L_DIV    = 27'd1 << 7,
        S_L_WR     = 27'd1 << 8,
        S_Q_LINE   = 27'd1 << 9,
        S_Q_RD     = 27'd1 << 10,
        S_Q_C_MUL  = 27'd1 << 11,
        S_Q_C_ACC  = 27'd1 << 12,
        S_Q_C_FIN  = 27'd1 << 13,
        S_Q_N_MUL  = 27'd1 << 14,
        S_Q_N_ACC  = 27'd1 << 15,
        S_Q_N_CHK  = 27'd1 << 16,
        S_Q_SQRT   = 27'd1 << 17,
        S_Q_M_MUL  = 27'd1 << 18,
        S_Q_M_GO   = 27'd1 << 19,
        S_Q_M_DIV  = 27'd1 << 20,
        S_Q_E_GO   = 27'd1 << 21,
        S_Q_E_DIV  = 27'd1 << 22,
        S_Q_T_MUL  = 27'd1 << 23,
        S_Q_T_ACC  = 27'd1 << 24,
        S_Q_SAT    = 27'd1 << 25,
        S_DONE     = 27'd1 << 26
    } state_t;

    typedef struct packed {
        logic signed [PW-1:0]       current;
        logic [2:0][PW-1:0]         anchor;
        logic [2:0][UW-1:0]         unit_dir;
    } entry_t;

    function automatic logic [WW-1:0] abs_w(input logic signed [WW-1:0] v);
        return v[WW-1] ? WW'(-v) : WW'(v);
    endfunction

    function automatic logic [CW-1:0] abs_c(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    entry_t line_mem [MAX_LINES];

    // control
    state_t           state_reg, state_next;
    logic [CFG_W-1:0] active_lines_reg, active_lines_next;
    logic             result_valid_reg, result_valid_next;
    logic             sq_busy_reg, sq_busy_next;
    logic             div_busy_reg, div_busy_next;

    // datapath
    in_word_t                item_reg, item_next;
    out_word_t               result_reg, result_next;
    out_word_t               pend_reg, pend_next;
    entry_t                  rd_entry_reg;
    logic signed [WW-1:0]    d_reg [3], d_next [3];
    logic [19:0]             m_reg, m_next;
    logic signed [UW-1:0]    u_reg [3], u_next [3];
    logic [LW-1:0]           len_reg, len_next;
    logic [2:0]              j_reg, j_next;
    logic [SQW-1:0]          sum_reg, sum_next;
    logic signed [61:0]      prod_reg, prod_next;
    logic signed [TW-1:0]    tprod_reg, tprod_next;
    logic [LCW-1:0]          line_reg, line_next;
    logic [LCW-1:0]          nlines_reg, nlines_next;
    logic signed [WW-1:0]    w_reg [3], w_next [3];
    logic signed [C24W-1:0]  c24_reg [3], c24_next [3];
    logic signed [CW-1:0]    c_reg [3], c_next [3];
    logic [RW-1:0]           r_reg, r_next;
    logic signed [MW-1:0]    mag_reg, mag_next;
    logic signed [EW-1:0]    e_reg, e_next;
    logic signed [ACCW-1:0]  acc_reg [3], acc_next [3];
    logic                    skip_reg, skip_next;
    logic [SQW-1:0]          sq_n_reg, sq_n_next;
    logic [SQW-1:0]          sq_res_reg, sq_res_next;
    logic [SQKW-1:0]         sq_k_reg, sq_k_next;
    logic [DNW-1:0]          div_num_reg, div_num_next;
    logic [DDW-1:0]          div_den_reg, div_den_next;
    logic [DDW:0]            div_rem_reg, div_rem_next;
    logic [DNW-1:0]          div_quo_reg, div_quo_next;
    logic [DCW-1:0]          div_cnt_reg, div_cnt_next;

    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_wr_addr, mem_rd_addr;
    entry_t                  mem_wr_data;
    logic [IXW-1:0]          idx_wide;
    logic signed [CW-1:0]    mul_a, mul_b;
    logic signed [61:0]      mul_full;
    logic signed [TW-1:0]    tmul_full;

    assign mul_full   = mul_a * mul_b;
    assign tmul_full  = mag_reg * e_reg;
    assign idx_wide   = IXW'(item_reg.entry_index);
    assign item_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result_word  = result_reg;

    always_comb
    begin
        logic [WW-1:0]          ad [3];
        logic [19:0]            mx;
        logic [SQW-1:0]         sq_bit, sq_t;
        logic [DDW:0]           rem_sh;
        logic signed [C24W-1:0] c_rnd;
        logic signed [TW-1:0]   t_rnd;
        logic signed [FW-1:0]   fld [3];
        logic                   sat;
        logic [1:0]             jj;

        state_next        = state_reg;
        active_lines_next = active_lines_reg;
        result_valid_next = result_valid_reg && !result_ready;
        sq_busy_next      = sq_busy_reg;
        div_busy_next     = div_busy_reg;
        item_next   = item_reg;
        result_next = result_reg;
        pend_next   = pend_reg;
        m_next      = m_reg;
        len_next    = len_reg;
        j_next      = j_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        tprod_next  = tprod_reg;
        line_next   = line_reg;
        nlines_next = nlines_reg;
        r_next      = r_reg;
        mag_next    = mag_reg;
        e_next      = e_reg;
        skip_next   = skip_reg;
        sq_n_next   = sq_n_reg;
        sq_res_next = sq_res_reg;
        sq_k_next   = sq_k_reg;
        div_num_next = div_num_reg;
        div_den_next = div_den_reg;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_cnt_next = div_cnt_reg;
        for (int k = 0; k < 3; k++)
        begin
            d_next[k]   = d_reg[k];
            u_next[k]   = u_reg[k];
            w_next[k]   = w_reg[k];
            c24_next[k] = c24_reg[k];
            c_next[k]   = c_reg[k];
            acc_next[k] = acc_reg[k];
        end
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wr_addr = idx_wide[AW-1:0];
        mem_rd_addr = line_reg[AW-1:0];
        mem_wr_data.current  = item_reg.current_amps;
        mem_wr_data.anchor   = {item_reg.pos_z, item_reg.pos_y, item_reg.pos_x};
        mem_wr_data.unit_dir = {u_reg[2], u_reg[1], u_reg[0]};
        mul_a = '0;
        mul_b = '0;
        jj    = j_reg[1:0];

        ad[0] = abs_w(WW'(item_reg.dir_x));
        ad[1] = abs_w(WW'(item_reg.dir_y));
        ad[2] = abs_w(WW'(item_reg.dir_z));
        mx = ad[0][19:0];
        if (ad[1][19:0] > mx)
            mx = ad[1][19:0];
        if (ad[2][19:0] > mx)
            mx = ad[2][19:0];

        c_rnd = '0;
        t_rnd = '0;
        sat   = 1'b0;
        for (int k = 0; k < 3; k++)
            fld[k] = '0;

        if (cfg_write_en)
            active_lines_next = cfg_write_data;

        // integer root, one result bit a step
        sq_bit = SQW'(1) << {sq_k_reg, 1'b0};
        sq_t   = sq_res_reg + sq_bit;
        if (sq_busy_reg)
        begin
            if (sq_n_reg >= sq_t)
            begin
                sq_n_next   = sq_n_reg - sq_t;
                sq_res_next = (sq_res_reg >> 1) + sq_bit;
            end
            else
                sq_res_next = sq_res_reg >> 1;
            if (sq_k_reg == '0)
                sq_busy_next = 1'b0;
            else
                sq_k_next = sq_k_reg - 1'b1;
        end

        // restoring divider, one quotient bit a step
        rem_sh = {div_rem_reg[DDW-1:0], div_num_reg[DNW-1]};
        if (div_busy_reg)
        begin
            div_num_next = {div_num_reg[DNW-2:0], 1'b0};
            if (rem_sh >= {1'b0, div_den_reg})
            begin
                div_rem_next = rem_sh - {1'b0, div_den_reg};
                div_quo_next = {div_quo_reg[DNW-2:0], 1'b1};
            end
            else
            begin
                div_rem_next = rem_sh;
                div_quo_next = {div_quo_reg[DNW-2:0], 1'b0};
            end
            if (div_cnt_reg == '0)
                div_busy_next = 1'b0;
            else
                div_cnt_next = div_cnt_reg - 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item_word;
                    if (item_word.operation == OP_LOAD)
                        state_next = S_L_CHK;
                    else
                    begin
                        line_next = '0;
                        skip_next = 1'b0;
                        for (int k = 0; k < 3; k++)
                            acc_next[k] = '0;
                        if (int'(active_lines_reg) > MAX_LINES)
                            nlines_next = LCW'(MAX_LINES);
                        else
                            nlines_next = LCW'(active_lines_reg);
                        state_next = S_Q_LINE;
                    end
                end
            end
            S_L_CHK:
            begin
                pend_next = '0;
                if (mx == '0)
                begin
                    pend_next.status = ST_ZERO_DIR;
                    state_next = S_DONE;
                end
                else if (int'(item_reg.entry_index) >= MAX_LINES)
                begin
                    pend_next.status = ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    d_next[0] = WW'(item_reg.dir_x);
                    d_next[1] = WW'(item_reg.dir_y);
                    d_next[2] = WW'(item_reg.dir_z);
                    m_next = mx;
                    state_next = S_L_SCALE;
                end
            end
            S_L_SCALE:
            begin
                if (m_reg < SCALE_FLOOR)
                begin
                    m_next = {m_reg[18:0], 1'b0};
                    for (int k = 0; k < 3; k++)
                        d_next[k] = d_reg[k] <<< 1;
                end
                else
                begin
                    j_next = '0;
                    sum_next = '0;
                    state_next = S_L_SQ_MUL;
                end
            end
            S_L_SQ_MUL:
            begin
                mul_a = CW'(d_reg[jj]);
                mul_b = CW'(d_reg[jj]);
                prod_next = mul_full;
                state_next = S_L_SQ_ACC;
            end
            S_L_SQ_ACC:
            begin
                sum_next = sum_reg + SQW'(prod_reg);
                if (j_reg == 3'd2)
                begin
                    sq_n_next = sum_next;
                    sq_res_next = '0;
                    sq_k_next = SQKW'(SQW / 2 - 1);
                    sq_busy_next = 1'b1;
                    state_next = S_L_SQRT;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_L_SQ_MUL;
                end
            end
            S_L_SQRT:
            begin
                if (!sq_busy_reg)
                begin
                    len_next = sq_res_reg[LW-1:0];
                    j_next = '0;
                    state_next = S_L_DIV_GO;
                end
            end
            S_L_DIV_GO:
            begin
                div_num_next = DNW'({abs_w(d_reg[jj]), 16'd0}) + DNW'(len_reg >> 1);
                div_den_next = DDW'(len_reg);
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = DCW'(DNW - 1);
                div_busy_next = 1'b1;
                state_next = S_L_DIV;
            end
            S_L_DIV:
            begin
                if (!div_busy_reg)
                begin
                    u_next[jj] = d_reg[jj][WW-1] ? -UW'(div_quo_reg) : UW'(div_quo_reg);
                    if (j_reg == 3'd2)
                        state_next = S_L_WR;
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        state_next = S_L_DIV_GO;
                    end
                end
            end
            S_L_WR:
            begin
                mem_we = 1'b1;
                pend_next = '0;
                pend_next.status = ST_OK;
                state_next = S_DONE;
            end
            S_Q_LINE:
            begin
                if (line_reg == nlines_reg)
                    state_next = S_Q_SAT;
                else
                begin
                    mem_re = 1'b1;
                    state_next = S_Q_RD;
                end
            end
            S_Q_RD:
            begin
                w_next[0] = WW'(item_reg.pos_x) - WW'($signed(rd_entry_reg.anchor[0]));
                w_next[1] = WW'(item_reg.pos_y) - WW'($signed(rd_entry_reg.anchor[1]));
                w_next[2] = WW'(item_reg.pos_z) - WW'($signed(rd_entry_reg.anchor[2]));
                for (int k = 0; k < 3; k++)
                    c24_next[k] = '0;
                j_next = '0;
                state_next = S_Q_C_MUL;
            end
            S_Q_C_MUL:
            begin
                case (j_reg)
                    3'd0:
                    begin
                        mul_a = CW'($signed(rd_entry_reg.unit_dir[1]));
                        mul_b = CW'(w_reg[2]);
                    end
                    3'd1:
                    begin
                        mul_a = CW'($signed(rd_entry_reg.unit_dir[2]));
                        mul_b = CW'(w_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = CW'($signed(rd_entry_reg.unit_dir[2]));
                        mul_b = CW'(w_reg[0]);
                    end
                    3'd3:
                    begin
                        mul_a = CW'($signed(rd_entry_reg.unit_dir[0]));
                        mul_b = CW'(w_reg[2]);
                    end
                    3'd4:
                    begin
                        mul_a = CW'($signed(rd_entry_reg.unit_dir[0]));
                        mul_b = CW'(w_reg[1]);
                    end
                    3'd5:
                    begin
                        mul_a = CW'($signed(rd_entry_reg.unit_dir[1]));
                        mul_b = CW'(w_reg[0]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                prod_next = mul_full;
                state_next = S_Q_C_ACC;
            end
            S_Q_C_ACC:
            begin
                if (j_reg[0])
                    c24_next[j_reg[2:1]] = c24_reg[j_reg[2:1]] - C24W'(prod_reg);
                else
                    c24_next[j_reg[2:1]] = c24_reg[j_reg[2:1]] + C24W'(prod_reg);
                if (j_reg == 3'd5)
                    state_next = S_Q_C_FIN;
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_Q_C_MUL;
                end
            end
            S_Q_C_FIN:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    c_rnd = c24_reg[k] + C24W'(128);
                    c_next[k] = CW'(c_rnd >>> 8);
                end
                j_next = '0;
                sum_next = '0;
                state_next = S_Q_N_MUL;
            end
            S_Q_N_MUL:
            begin
                mul_a = c_reg[jj];
                mul_b = c_reg[jj];
                prod_next = mul_full;
                state_next = S_Q_N_ACC;
            end
            S_Q_N_ACC:
            begin
                sum_next = sum_reg + SQW'(prod_reg);
                if (j_reg == 3'd2)
                    state_next = S_Q_N_CHK;
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_Q_N_MUL;
                end
            end
            S_Q_N_CHK:
            begin
                if (sum_reg == '0)
                begin
                    skip_next = 1'b1;
                    line_next = LCW'(line_reg + 1'b1);
                    state_next = S_Q_LINE;
                end
                else
                begin
                    sq_n_next = sum_reg;
                    sq_res_next = '0;
                    sq_k_next = SQKW'(SQW / 2 - 1);
                    sq_busy_next = 1'b1;
                    state_next = S_Q_SQRT;
                end
            end
            S_Q_SQRT:
            begin
                if (!sq_busy_reg)
                begin
                    r_next = sq_res_reg[RW-1:0];
                    state_next = S_Q_M_MUL;
                end
            end
            S_Q_M_MUL:
            begin
                mul_a = CW'($signed({1'b0, abs_w(WW'(rd_entry_reg.current))}));
                mul_b = CW'($signed({1'b0, INV_TWO_PI_Q32}));
                prod_next = mul_full;
                state_next = S_Q_M_GO;
            end
            S_Q_M_GO:
            begin
                div_num_next = DNW'(prod_reg[DNW-1:0]) + DNW'({r_reg, 7'd0});
                div_den_next = DDW'({r_reg, 8'd0});
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = DCW'(DNW - 1);
                div_busy_next = 1'b1;
                state_next = S_Q_M_DIV;
            end
            S_Q_M_DIV:
            begin
                if (!div_busy_reg)
                begin
                    mag_next = rd_entry_reg.current[PW-1] ? -MW'(div_quo_reg)
                                                          : MW'(div_quo_reg);
                    j_next = '0;
                    state_next = S_Q_E_GO;
                end
            end
            S_Q_E_GO:
            begin
                div_num_next = DNW'({abs_c(c_reg[jj]), 16'd0}) + DNW'(r_reg >> 1);
                div_den_next = DDW'(r_reg);
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = DCW'(DNW - 1);
                div_busy_next = 1'b1;
                state_next = S_Q_E_DIV;
            end
            S_Q_E_DIV:
            begin
                if (!div_busy_reg)
                begin
                    e_next = c_reg[jj][CW-1] ? -EW'(div_quo_reg) : EW'(div_quo_reg);
                    state_next = S_Q_T_MUL;
                end
            end
            S_Q_T_MUL:
            begin
                tprod_next = tmul_full;
                state_next = S_Q_T_ACC;
            end
            S_Q_T_ACC:
            begin
                t_rnd = tprod_reg + TW'(32768);
                acc_next[jj] = acc_reg[jj] + ACCW'(t_rnd >>> 16);
                if (j_reg == 3'd2)
                begin
                    line_next = LCW'(line_reg + 1'b1);
                    state_next = S_Q_LINE;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_Q_E_GO;
                end
            end
            S_Q_SAT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (acc_reg[k] > ACC_POS_LIM)
                    begin
                        fld[k] = FIELD_MAX;
                        sat = 1'b1;
                    end
                    else if (acc_reg[k] < ACC_NEG_LIM)
                    begin
                        fld[k] = FIELD_MIN;
                        sat = 1'b1;
                    end
                    else
                        fld[k] = FW'(acc_reg[k]);
                end
                pend_next.field_x = fld[0];
                pend_next.field_y = fld[1];
                pend_next.field_z = fld[2];
                pend_next.status  = sat ? ST_SAT : (skip_reg ? ST_SKIP : ST_OK);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next = pend_reg;
                    result_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            active_lines_reg <= '0;
            result_valid_reg <= 1'b0;
            sq_busy_reg      <= 1'b0;
            div_busy_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_lines_reg <= active_lines_next;
            result_valid_reg <= result_valid_next;
            sq_busy_reg      <= sq_busy_next;
            div_busy_reg     <= div_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        result_reg  <= result_next;
        pend_reg    <= pend_next;
        m_reg       <= m_next;
        len_reg     <= len_next;
        j_reg       <= j_next;
        sum_reg     <= sum_next;
        prod_reg    <= prod_next;
        tprod_reg   <= tprod_next;
        line_reg    <= line_next;
        nlines_reg  <= nlines_next;
        r_reg       <= r_next;
        mag_reg     <= mag_next;
        e_reg       <= e_next;
        skip_reg    <= skip_next;
        sq_n_reg    <= sq_n_next;
        sq_res_reg  <= sq_res_next;
        sq_k_reg    <= sq_k_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_cnt_reg <= div_cnt_next;
        for (int k = 0; k < 3; k++)
        begin
            d_reg[k]   <= d_next[k];
            u_reg[k]   <= u_next[k];
            w_reg[k]   <= w_next[k];
            c24_reg[k] <= c24_next[k];
            c_reg[k]   <= c_next[k];
            acc_reg[k] <= acc_next[k];
        end
    end

    // line table
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_wr_addr] <= mem_wr_data;
        if (mem_re)
            rd_entry_reg <= line_mem[mem_rd_addr];
    end

endmodule

// ----- design/lcmf_checker.sv -----
// Port-level checks for the line current field block, bound to the top level.
// Depends on lcmf_pkg and line_current_magnetic_field_defines.svh.
`include "line_current_magnetic_field_defines.svh"

module lcmf_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input lcmf_pkg::in_word_t  item_word,
    input logic                result_valid,
    input logic                result_ready,
    input lcmf_pkg::out_word_t result_word
);
    import lcmf_pkg::*;

    logic zero_fields, extreme_field;

    assign zero_fields = (result_word.field_x == '0) && (result_word.field_y == '0)
                      && (result_word.field_z == '0);
    assign extreme_field = (result_word.field_x == FIELD_MAX)
                        || (result_word.field_x == FIELD_MIN)
                        || (result_word.field_y == FIELD_MAX)
                        || (result_word.field_y == FIELD_MIN)
                        || (result_word.field_z == FIELD_MAX)
                        || (result_word.field_z == FIELD_MIN);

    // one word in work at a time
    `LCMF_ASSERT_NEXT(a_one_in_flight, clk, rst_n, item_valid && item_ready, !item_ready)
    // a rejected direction leaves no field
    `LCMF_ASSERT_NOW(a_zero_dir_fields, clk, rst_n,
                     result_valid && (result_word.status == ST_ZERO_DIR), zero_fields)
    // saturated status means a clipped component
    `LCMF_ASSERT_NOW(a_sat_clipped, clk, rst_n,
                     result_valid && (result_word.status == ST_SAT), extreme_field)
    // stalled result word holds
    `LCMF_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
                      result_valid && $stable(result_word))

endmodule

bind line_current_magnetic_field lcmf_checker u_lcmf_checker (.*);
